[design/dthash_pkg.sv]
// ----------------------------------------------------------------------------
// dthash_pkg
// Shared types and constants for the chained hash device table.
// ----------------------------------------------------------------------------
package dthash_pkg;

  localparam int DEF_TABLE_ENTRIES = 64;
  localparam int DEF_BUCKET_COUNT  = 64;

  localparam int MAC_W   = 48;
  localparam int IP_W    = 32;
  localparam int VLAN_W  = 12;
  localparam int TYPE_W  = 8;
  localparam int OP_W    = 2;
  localparam int BKT_IN_W = 6;
  localparam int STAT_W  = 3;
  localparam int ENTRY_W = MAC_W + IP_W + VLAN_W + TYPE_W;

  localparam logic [TYPE_W-1:0] KEEP_BIT = 8'h20;

  localparam logic [OP_W-1:0] OP_GET    = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [STAT_W-1:0] ST_UPDATED   = 3'd0;
  localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_CLEARED   = 3'd4;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_CLEAR,
    RES_MISS,
    RES_FULL,
    RES_HIT_LOOKUP,
    RES_HIT_UPDATE,
    RES_INSERT
  } res_sel_t;

  typedef struct packed {
    logic     load;
    logic     clear_tbl;
    logic     start_walk;
    logic     step;
    logic     upd;
    logic     ins;
    logic     link;
    logic     out_load;
    res_sel_t res_sel;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] in_op;
    logic [OP_W-1:0] op;
    logic            head_nz;
    logic            hit;
    logic            next_nz;
    logic            full;
    logic            tail_nz;
    logic            out_free;
  } stat_t;

endpackage

[design/dthash_ram.sv]
// ----------------------------------------------------------------------------
// dthash_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module dthash_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/dthash_ctrl.sv]
// ----------------------------------------------------------------------------
// dthash_ctrl
// Sequencer for get, lookup and clear requests over the table datapath.
// ----------------------------------------------------------------------------
module dthash_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  dthash_pkg::stat_t st,
  output dthash_pkg::cmd_t  cmd
);
  import dthash_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_HEAD   = 6'b000010,
    S_WALK   = 6'b000100,
    S_INSERT = 6'b001000,
    S_LINK   = 6'b010000,
    S_RESP   = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.res_sel = RES_NONE;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (st.in_op == OP_CLEAR) begin
            cmd.clear_tbl = 1'b1;
            cmd.res_sel   = RES_CLEAR;
            state_next    = S_RESP;
          end else if (st.in_op == OP_GET || st.in_op == OP_LOOKUP) begin
            state_next = S_HEAD;
          end else begin
            cmd.res_sel = RES_MISS;
            state_next  = S_RESP;
          end
        end
      end
      S_HEAD: begin
        if (st.head_nz) begin
          cmd.start_walk = 1'b1;
          state_next     = S_WALK;
        end else if (st.op == OP_LOOKUP) begin
          cmd.res_sel = RES_MISS;
          state_next  = S_RESP;
        end else if (st.full) begin
          cmd.res_sel = RES_FULL;
          state_next  = S_RESP;
        end else begin
          state_next = S_INSERT;
        end
      end
      S_WALK: begin
        if (st.hit) begin
          if (st.op == OP_LOOKUP) begin
            cmd.res_sel = RES_HIT_LOOKUP;
          end else begin
            cmd.upd     = 1'b1;
            cmd.res_sel = RES_HIT_UPDATE;
          end
          state_next = S_RESP;
        end else begin
          cmd.step = 1'b1;
          if (!st.next_nz) begin
            if (st.op == OP_LOOKUP) begin
              cmd.res_sel = RES_MISS;
              state_next  = S_RESP;
            end else if (st.full) begin
              cmd.res_sel = RES_FULL;
              state_next  = S_RESP;
            end else begin
              state_next = S_INSERT;
            end
          end
        end
      end
      S_INSERT: begin
        cmd.ins     = 1'b1;
        cmd.res_sel = RES_INSERT;
        state_next  = st.tail_nz ? S_LINK : S_RESP;
      end
      S_LINK: begin
        cmd.link   = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[design/dthash_dp.sv]
// ----------------------------------------------------------------------------
// dthash_dp
// Table storage, chain walk registers, fill count and result registers.
// ----------------------------------------------------------------------------
module dthash_dp #(
  parameter int TABLE_ENTRIES = dthash_pkg::DEF_TABLE_ENTRIES,
  parameter int BUCKET_COUNT  = dthash_pkg::DEF_BUCKET_COUNT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  dthash_pkg::cmd_t                  cmd,
  output dthash_pkg::stat_t                 st,
  input  logic                              cfg_valid,
  input  logic                              cfg_data,
  input  logic [dthash_pkg::OP_W-1:0]       opcode,
  input  logic [dthash_pkg::MAC_W-1:0]      mac_address,
  input  logic [dthash_pkg::IP_W-1:0]       ip_address,
  input  logic [dthash_pkg::VLAN_W-1:0]     vlan_id,
  input  logic [dthash_pkg::TYPE_W-1:0]     device_type,
  input  logic [dthash_pkg::BKT_IN_W-1:0]   bucket,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [$clog2(TABLE_ENTRIES+1)-1:0] slot,
  output logic [dthash_pkg::STAT_W-1:0]     status,
  output logic [dthash_pkg::TYPE_W-1:0]     stored_type
);
  import dthash_pkg::*;

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int SLOT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int BKT_W  = $clog2(BUCKET_COUNT);
  localparam int MOD_W  = BKT_IN_W + BKT_W + 1;
  localparam logic [SLOT_W-1:0] SLOT_ONE = SLOT_W'(1);
  localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(TABLE_ENTRIES);

  logic              match_ip;
  logic [OP_W-1:0]   req_op;
  logic [MAC_W-1:0]  req_mac;
  logic [IP_W-1:0]   req_ip;
  logic [VLAN_W-1:0] req_vlan;
  logic [TYPE_W-1:0] req_type;
  logic [BKT_W-1:0]  req_bkt;
  logic [SLOT_W-1:0] cur, tail, count;
  logic [BUCKET_COUNT-1:0] head_valid;
  logic              hv_q;
  logic [SLOT_W-1:0] res_slot;
  logic [STAT_W-1:0] res_status;
  logic [TYPE_W-1:0] res_type;

  logic [BKT_W-1:0]  in_bkt;
  logic [MOD_W-1:0]  mod_r;
  logic [SLOT_W-1:0] head_q, next_q, free_slot;
  logic [ENTRY_W-1:0] data_q;
  logic [MAC_W-1:0]  d_mac;
  logic [IP_W-1:0]   d_ip;
  logic [TYPE_W-1:0] d_type, merged;
  logic [IDX_W-1:0]  rd_addr, dwr_addr, nwr_addr;
  logic [ENTRY_W-1:0] dwr_data;
  logic [SLOT_W-1:0] nwr_data;
  logic [SLOT_W-1:0] rd_slot, cur_m1, tail_m1;

  // reduce the bucket number modulo the bucket count
  always_comb begin
    mod_r = MOD_W'(bucket);
    for (int i = BKT_IN_W - 1; i >= 0; i--) begin
      if (mod_r >= (MOD_W'(BUCKET_COUNT) << i)) begin
        mod_r = mod_r - (MOD_W'(BUCKET_COUNT) << i);
      end
    end
    in_bkt = mod_r[BKT_W-1:0];
  end

  assign d_mac  = data_q[ENTRY_W-1 -: MAC_W];
  assign d_ip   = data_q[TYPE_W+VLAN_W +: IP_W];
  assign d_type = data_q[TYPE_W-1:0];
  assign merged = req_type | (d_type & KEEP_BIT);
  assign free_slot = count + SLOT_ONE;

  assign rd_slot  = (cmd.start_walk ? head_q : next_q) - SLOT_ONE;
  assign rd_addr  = rd_slot[IDX_W-1:0];
  assign cur_m1   = cur - SLOT_ONE;
  assign tail_m1  = tail - SLOT_ONE;
  assign dwr_addr = cmd.upd ? cur_m1[IDX_W-1:0] : count[IDX_W-1:0];
  assign dwr_data = cmd.upd ? {d_mac, req_ip, req_vlan, merged}
                            : {req_mac, req_ip, req_vlan, req_type};
  assign nwr_addr = cmd.link ? tail_m1[IDX_W-1:0] : count[IDX_W-1:0];
  assign nwr_data = cmd.link ? res_slot : '0;

  dthash_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_data (
    .clk   (clk),
    .we    (cmd.upd || cmd.ins),
    .waddr (dwr_addr),
    .wdata (dwr_data),
    .raddr (rd_addr),
    .rdata (data_q)
  );

  dthash_ram #(.WIDTH(SLOT_W), .DEPTH(TABLE_ENTRIES)) u_next (
    .clk   (clk),
    .we    (cmd.ins || cmd.link),
    .waddr (nwr_addr),
    .wdata (nwr_data),
    .raddr (rd_addr),
    .rdata (next_q)
  );

  dthash_ram #(.WIDTH(SLOT_W), .DEPTH(BUCKET_COUNT)) u_head (
    .clk   (clk),
    .we    (cmd.ins && (tail == '0)),
    .waddr (req_bkt),
    .wdata (free_slot),
    .raddr (in_bkt),
    .rdata (head_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      match_ip   <= 1'b1;
      count      <= '0;
      head_valid <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        match_ip <= cfg_data;
      end
      if (cmd.clear_tbl) begin
        count      <= '0;
        head_valid <= '0;
      end else if (cmd.ins) begin
        count <= free_slot;
        if (tail == '0) begin
          head_valid[req_bkt] <= 1'b1;
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op   <= opcode;
      req_mac  <= mac_address;
      req_ip   <= ip_address;
      req_vlan <= vlan_id;
      req_type <= device_type;
      req_bkt  <= in_bkt;
      hv_q     <= head_valid[in_bkt];
      tail     <= '0;
    end else if (cmd.step) begin
      tail <= cur;
    end
    if (cmd.start_walk) begin
      cur <= head_q;
    end else if (cmd.step) begin
      cur <= next_q;
    end
    unique case (cmd.res_sel)
      RES_CLEAR: begin
        res_slot <= '0; res_status <= ST_CLEARED; res_type <= '0;
      end
      RES_MISS: begin
        res_slot <= '0; res_status <= ST_NOT_FOUND; res_type <= '0;
      end
      RES_FULL: begin
        res_slot <= '0; res_status <= ST_FULL; res_type <= '0;
      end
      RES_HIT_LOOKUP: begin
        res_slot <= cur; res_status <= ST_UPDATED; res_type <= d_type;
      end
      RES_HIT_UPDATE: begin
        res_slot <= cur; res_status <= ST_UPDATED; res_type <= merged;
      end
      RES_INSERT: begin
        res_slot <= free_slot; res_status <= ST_INSERTED; res_type <= req_type;
      end
      default: begin
      end
    endcase
    if (cmd.out_load) begin
      slot        <= res_slot;
      status      <= res_status;
      stored_type <= res_type;
    end
  end

  always_comb begin
    st.in_op    = opcode;
    st.op       = req_op;
    st.head_nz  = hv_q && (head_q != '0);
    st.hit      = (d_mac == req_mac) && (!match_ip || (d_ip == req_ip));
    st.next_nz  = (next_q != '0);
    st.full     = (count == SLOT_MAX);
    st.tail_nz  = (tail != '0);
    st.out_free = !out_valid || out_ready;
  end

endmodule

[design/device_table_hash_insert_lookup.sv]
// ----------------------------------------------------------------------------
// device_table_hash_insert_lookup
// Chained hash device table with get (insert or update), lookup and clear.
//
//   channel  signals                                           direction
//   in       in_valid/in_ready, opcode, mac_address, ip_address,
//            vlan_id, device_type, bucket                       request in
//   out      out_valid/out_ready, slot, status, stored_type     result out
//   cfg      cfg_valid/cfg_ready, cfg_data (match_ip)           write in
//
// A clear or unknown opcode goes straight to the response; a get or lookup
// reads the bucket head and walks the chain, then a get may insert and link.
// The chain walk reads one entry per cycle from the slot RAMs.
// Slots fill in order, so a fill count gives the lowest free slot.
// Reset empties the table at once and sets match_ip.
// A new request is taken while the last result waits on out_ready.
// ----------------------------------------------------------------------------
module device_table_hash_insert_lookup #(
  parameter int TABLE_ENTRIES = dthash_pkg::DEF_TABLE_ENTRIES,
  parameter int BUCKET_COUNT  = dthash_pkg::DEF_BUCKET_COUNT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [dthash_pkg::OP_W-1:0]        opcode,
  input  logic [dthash_pkg::MAC_W-1:0]       mac_address,
  input  logic [dthash_pkg::IP_W-1:0]        ip_address,
  input  logic [dthash_pkg::VLAN_W-1:0]      vlan_id,
  input  logic [dthash_pkg::TYPE_W-1:0]      device_type,
  input  logic [dthash_pkg::BKT_IN_W-1:0]    bucket,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [$clog2(TABLE_ENTRIES+1)-1:0] slot,
  output logic [dthash_pkg::STAT_W-1:0]      status,
  output logic [dthash_pkg::TYPE_W-1:0]      stored_type
);
  import dthash_pkg::*;

  cmd_t  cmd;
  stat_t st;

  assign cfg_ready = 1'b1;

  dthash_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  dthash_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .BUCKET_COUNT  (BUCKET_COUNT)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .opcode      (opcode),
    .mac_address (mac_address),
    .ip_address  (ip_address),
    .vlan_id     (vlan_id),
    .device_type (device_type),
    .bucket      (bucket),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .slot        (slot),
    .status      (status),
    .stored_type (stored_type)
  );

endmodule

[dv/device_table_hash_insert_lookup_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// device_table_hash_insert_lookup_test
// Checks the chained hash device table against a behavioral table model:
// get, lookup, clear and unknown requests under both IP match settings,
// with chains, table full, random idling on both channels and a long stall.
// ----------------------------------------------------------------------------
module device_table_hash_insert_lookup_test;
  import dthash_pkg::*;

  localparam int ENTRIES = 64;
  localparam int BUCKETS = 64;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [6:0]        slot;
    logic [STAT_W-1:0] status;
    logic [TYPE_W-1:0] stored_type;
  } result_t;

  logic clk, rst;
  logic cfg_valid, cfg_ready, cfg_data;
  logic in_valid, in_ready;
  logic [OP_W-1:0] opcode;
  logic [MAC_W-1:0] mac_address;
  logic [IP_W-1:0] ip_address;
  logic [VLAN_W-1:0] vlan_id;
  logic [TYPE_W-1:0] device_type;
  logic [BKT_IN_W-1:0] bucket;
  logic out_valid, out_ready;
  logic [6:0] slot;
  logic [STAT_W-1:0] status;
  logic [TYPE_W-1:0] stored_type;

  device_table_hash_insert_lookup u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
    .mac_address(mac_address), .ip_address(ip_address), .vlan_id(vlan_id),
    .device_type(device_type), .bucket(bucket),
    .out_valid(out_valid), .out_ready(out_ready), .slot(slot),
    .status(status), .stored_type(stored_type)
  );

  // table model
  bit          tbl_used [ENTRIES];
  bit [47:0]   tbl_mac [ENTRIES];
  bit [31:0]   tbl_ip [ENTRIES];
  bit [11:0]   tbl_vlan [ENTRIES];
  bit [7:0]    tbl_type [ENTRIES];
  int unsigned tbl_next [ENTRIES];
  int unsigned tbl_head [BUCKETS];
  bit          want_ip;

  result_t expected_results[$];
  int  mismatches;
  int  idle_cycles;
  bit  hold_off;
  bit  timed_out;
  logic [MAC_W-1:0] mac_pool[8];

  function automatic void table_clear();
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_used[i] = 0; tbl_mac[i] = 0; tbl_ip[i] = 0;
      tbl_vlan[i] = 0; tbl_type[i] = 0; tbl_next[i] = 0;
    end
    for (int b = 0; b < BUCKETS; b++) tbl_head[b] = 0;
  endfunction

  function automatic int unsigned chain_find(int unsigned b, bit [47:0] m, bit [31:0] a,
                                             output int unsigned tail);
    int unsigned cur;
    cur = tbl_head[b];
    tail = 0;
    for (int n = 0; n < ENTRIES; n++) begin
      if (cur == 0 || cur > ENTRIES) break;
      tail = cur;
      if (tbl_mac[cur-1] == m && (!want_ip || tbl_ip[cur-1] == a)) return cur;
      cur = tbl_next[cur-1];
    end
    return 0;
  endfunction

  function automatic result_t table_apply(bit [1:0] op, bit [47:0] m, bit [31:0] a,
                                          bit [11:0] v, bit [7:0] t, bit [5:0] b);
    result_t r;
    int unsigned hit, tail, fr, b_i;
    b_i = b % BUCKETS;
    r = '{slot: 0, status: ST_NOT_FOUND, stored_type: 0};
    if (op == OP_CLEAR) begin
      table_clear();
      r.status = ST_CLEARED;
    end else if (op == OP_LOOKUP) begin
      hit = chain_find(b_i, m, a, tail);
      if (hit != 0) begin
        r.slot = 7'(hit); r.status = ST_UPDATED; r.stored_type = tbl_type[hit-1];
      end
    end else if (op == OP_GET) begin
      hit = chain_find(b_i, m, a, tail);
      if (hit != 0) begin
        tbl_ip[hit-1] = a;
        tbl_vlan[hit-1] = v;
        tbl_type[hit-1] = t | (tbl_type[hit-1] & KEEP_BIT);
        r.slot = 7'(hit); r.status = ST_UPDATED; r.stored_type = tbl_type[hit-1];
      end else begin
        fr = 0;
        for (int i = 0; i < ENTRIES; i++)
          if (!tbl_used[i] && fr == 0) fr = i + 1;
        if (fr == 0) r.status = ST_FULL;
        else begin
          if (tail != 0 && tail <= ENTRIES) tbl_next[tail-1] = fr;
          else tbl_head[b_i] = fr;
          tbl_used[fr-1] = 1; tbl_mac[fr-1] = m; tbl_ip[fr-1] = a;
          tbl_vlan[fr-1] = v; tbl_type[fr-1] = t; tbl_next[fr-1] = 0;
          r.slot = 7'(fr); r.status = ST_INSERTED; r.stored_type = t;
        end
      end
    end
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // send one request, then maybe a gap
  task automatic send_request(bit [1:0] op, bit [47:0] m, bit [31:0] a,
                              bit [11:0] v, bit [7:0] t, bit [5:0] b, int gap);
    in_valid <= 1; opcode <= op; mac_address <= m; ip_address <= a;
    vlan_id <= v; device_type <= t; bucket <= b;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(table_apply(op, m, a, v, t, b));
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_match_ip(bit value);
    cfg_valid <= 1; cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    want_ip = value;
  endtask

  task automatic test_directed();
    send_request(OP_LOOKUP, 48'h0, 32'h0, 12'h0, 8'h0, 6'd0, 0);
    send_request(OP_GET, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF, 8'hFF, 6'd63, 0);
    send_request(OP_GET, 48'h0, 32'h0, 12'h0, 8'h00, 6'd63, 1);
    send_request(OP_GET, 48'h1, 32'h5, 12'h1, 8'h20, 6'd63, 0);
    send_request(OP_GET, 48'h1, 32'h5, 12'h2, 8'h01, 6'd63, 0);
    send_request(OP_GET, 48'h1, 32'h6, 12'h3, 8'h02, 6'd63, 0);
    send_request(OP_LOOKUP, 48'h1, 32'h5, 12'h0, 8'h0, 6'd63, 2);
    send_request(OP_LOOKUP, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 12'h0, 8'h0, 6'd63, 0);
    send_request(OP_LOOKUP, 48'h1, 32'h7, 12'h0, 8'h0, 6'd63, 0);
    send_request(2'd3, 48'h1, 32'h5, 12'h0, 8'h0, 6'd63, 0);
    send_request(OP_CLEAR, 48'h0, 32'h0, 12'h0, 8'h0, 6'd0, 0);
    send_request(OP_LOOKUP, 48'h1, 32'h5, 12'h0, 8'h0, 6'd63, 0);
    drain();
  endtask

  task automatic test_match_mac_only();
    write_match_ip(0);
    send_request(OP_GET, 48'hA, 32'h1, 12'h5, 8'h20, 6'd3, 0);
    send_request(OP_GET, 48'hA, 32'h2, 12'h6, 8'h04, 6'd3, 0);
    send_request(OP_LOOKUP, 48'hA, 32'h9, 12'h0, 8'h0, 6'd3, 0);
    send_request(OP_CLEAR, 48'h0, 32'h0, 12'h0, 8'h0, 6'd0, 0);
    drain();
    write_match_ip(1);
  endtask

  task automatic test_table_full();
    for (int i = 0; i < ENTRIES + 3; i++)
      send_request(OP_GET, 48'h100 + i, i, 12'(i), 8'(i), 6'(i % 4), 0);
    send_request(OP_GET, 48'h100, 32'd0, 12'd9, 8'hDF, 6'd0, 0);
    send_request(OP_LOOKUP, 48'h100 + ENTRIES - 1, 32'(ENTRIES - 1), 12'h0, 8'h0, 6'd3, 0);
    send_request(OP_CLEAR, 48'h0, 32'h0, 12'h0, 8'h0, 6'd0, 0);
    drain();
  endtask

  task automatic random_burst(int count);
    int burst;
    int n;
    bit [1:0] op;
    bit [47:0] m;
    bit [31:0] a;
    bit [5:0] b;
    int k;
    n = 0;
    burst = $urandom_range(1, 12);
    while (n < count) begin
      k = $urandom_range(0, 99);
      op = (k < 60) ? OP_GET : (k < 92) ? OP_LOOKUP : (k < 96) ? OP_CLEAR : 2'd3;
      k = $urandom_range(0, 7);
      if ($urandom_range(0, 9) < 8) m = mac_pool[k];
      else m = 48'({$urandom, $urandom});
      a = ($urandom_range(0, 3) != 0) ? {24'h0, 5'h0, k[2:0]} : $urandom;
      b = ($urandom_range(0, 3) != 0) ? {3'b0, k[2:0]} : 6'($urandom_range(0, 63));
      burst--;
      send_request(op, m, a, 12'($urandom), 8'($urandom), b,
                   (burst == 0) ? $urandom_range(0, 10) : 0);
      if (burst == 0) burst = $urandom_range(1, 12);
      n++;
    end
    drain();
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 4; phase++) begin
      for (int i = 0; i < 8; i++) mac_pool[i] = 48'({$urandom, $urandom});
      mac_pool[7] = 48'hFFFF_FFFF_FFFF;
      write_match_ip(phase[0]);
      random_burst(280);
    end
    write_match_ip(1);
  endtask

  task automatic test_backpressure();
    hold_off = 1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 20; i++)
        send_request(OP_GET, 48'({$urandom, $urandom}), $urandom, 12'($urandom),
                     8'($urandom), 6'($urandom_range(0, 63)), 0);
    join
    drain();
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    if (rst || hold_off) out_ready <= 0;
    else out_ready <= ($urandom_range(0, 31) < 24) || ($urandom_range(0, 7) == 0);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h %h %h", slot, status, stored_type);
      end else begin
        result_t e;
        e = expected_results.pop_front();
        if (slot !== e.slot || status !== e.status || stored_type !== e.stored_type) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp slot %0d status %0d type %h, got %0d %0d %h",
                     e.slot, e.status, e.stored_type, slot, status, stored_type);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out <= 1;
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst = 1; cfg_valid = 0; cfg_data = 0; in_valid = 0; opcode = 0;
    mac_address = 0; ip_address = 0; vlan_id = 0; device_type = 0; bucket = 0;
    out_ready = 0; hold_off = 0; mismatches = 0; idle_cycles = 0; timed_out = 0;
    table_clear();
    want_ip = 1;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_match_mac_only();
    test_table_full();
    test_backpressure();
    test_random();
    if (mismatches == 0 && expected_results.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
